>>> rtl/core/gvtn_pkg.sv
// gvtn_pkg: shared types, codes and helper functions of the gvt token ring node
// no dependencies; compiled first
`default_nettype none

package gvtn_pkg;

  localparam int TIME_BITS = 32;
  localparam int ID_BITS   = 10;
  localparam int CNT_BITS  = 11;
  localparam int PER_BITS  = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  typedef logic [TIME_BITS-1:0] tstamp_t;
  localparam tstamp_t TIME_INF = '1;

  // action codes
  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_INITIATE = 3'd1;
  localparam logic [2:0] ACT_MSG_SENT = 3'd2;
  localparam logic [2:0] ACT_MSG_RECV = 3'd3;
  localparam logic [2:0] ACT_SEND_TOK = 3'd4;
  localparam logic [2:0] ACT_TOK_ARR  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_ID    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_COUNT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GVT_PERIOD = 2'd2;

  localparam logic COLOR_WHITE = 1'b0;
  localparam logic COLOR_RED   = 1'b1;

  typedef struct packed {
    logic [2:0]         action;
    tstamp_t            send_time;
    logic               recv_color;
    tstamp_t            lvt_local;
    tstamp_t            in_clock;
    tstamp_t            in_send_min;
    logic signed [31:0] in_count;
  } in_item_t;

  typedef struct packed {
    logic               flag;
    logic               tag_color;
    logic               token_valid;
    logic [ID_BITS-1:0] token_dest;
    tstamp_t            token_clock;
    tstamp_t            token_send_min;
    logic signed [31:0] token_count;
    logic               gvt_valid;
    tstamp_t            gvt_value;
  } res_t;

  function automatic tstamp_t tmin(input tstamp_t a, input tstamp_t b);
    tmin = (a < b) ? a : b;
  endfunction

  // clamp a widened sum to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [33:0] s);
    logic signed [31:0] r;
    if (s[33:31] inside {3'b000, 3'b111}) begin
      r = s[31:0];
    end else if (s[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    sat32 = r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/gvtn_if.sv
// gvtn_if: valid/ready channel interfaces for configuration, events and results
// depends on gvtn_pkg
`default_nettype none

interface gvtn_cfg_if import gvtn_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface gvtn_in_if import gvtn_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  tstamp_t            send_time;
  logic               recv_color;
  tstamp_t            lvt_local;
  tstamp_t            in_clock;
  tstamp_t            in_send_min;
  logic signed [31:0] in_count;

  modport source (output valid, output action, output send_time, output recv_color,
                  output lvt_local, output in_clock, output in_send_min,
                  output in_count, input ready);
  modport sink   (input valid, input action, input send_time, input recv_color,
                  input lvt_local, input in_clock, input in_send_min,
                  input in_count, output ready);
endinterface

interface gvtn_out_if import gvtn_pkg::*; ;
  logic               valid;
  logic               ready;
  logic               flag;
  logic               tag_color;
  logic               token_valid;
  logic [ID_BITS-1:0] token_dest;
  tstamp_t            token_clock;
  tstamp_t            token_send_min;
  logic signed [31:0] token_count;
  logic               gvt_valid;
  tstamp_t            gvt_value;

  modport source (output valid, output flag, output tag_color, output token_valid,
                  output token_dest, output token_clock, output token_send_min,
                  output token_count, output gvt_valid, output gvt_value, input ready);
  modport sink   (input valid, input flag, input tag_color, input token_valid,
                  input token_dest, input token_clock, input token_send_min,
                  input token_count, input gvt_valid, input gvt_value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gvtn_dest_div.sv
// gvtn_dest_div: iterative remainder unit, dest = (node_id + 1) mod node_count
// one quotient bit per cycle, restarted on each write of node_id or node_count
// depends on gvtn_pkg
`default_nettype none

module gvtn_dest_div import gvtn_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [ID_BITS-1:0] node_id,
  input  wire logic [CNT_BITS-1:0] node_count,
  output logic                    busy,
  output logic [ID_BITS-1:0]      dest
);

  localparam int STEP_BITS  = $clog2(CNT_BITS);
  localparam int SHIFT_BITS = 2 * CNT_BITS - 1;
  localparam logic [STEP_BITS-1:0] STEP_TOP = STEP_BITS'(CNT_BITS - 1);

  logic                  busy_r;
  logic [ID_BITS-1:0]    dest_r;
  logic [CNT_BITS-1:0]   rem_r, rem_nxt;
  logic [CNT_BITS-1:0]   div_r;
  logic [STEP_BITS-1:0]  step_r;
  logic [SHIFT_BITS-1:0] shifted;

  always_comb begin
    shifted = {{(SHIFT_BITS-CNT_BITS){1'b0}}, div_r} << step_r;
    rem_nxt = rem_r;
    if ({{(SHIFT_BITS-CNT_BITS){1'b0}}, rem_r} >= shifted) begin
      rem_nxt = rem_r - shifted[CNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dest_r <= '0;
      rem_r  <= '0;
      div_r  <= '0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      rem_r  <= {1'b0, node_id} + CNT_BITS'(1);
      div_r  <= node_count;
      step_r <= STEP_TOP;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      step_r <= step_r - STEP_BITS'(1);
      if (step_r == '0) begin
        busy_r <= 1'b0;
        // empty ring sends to node zero
        dest_r <= (div_r == '0) ? '0 : rem_nxt[ID_BITS-1:0];
      end
    end
  end

  assign busy = busy_r;
  assign dest = dest_r;

`ifndef ASSERT_OFF
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r <= STEP_TOP)
    else $error("divider step out of range");
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && step_r == '0 && div_r != '0 |-> rem_nxt < div_r)
    else $error("remainder not below divisor at finish");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not start");
`endif

endmodule

`default_nettype wire

>>> rtl/core/gvt_token_ring_node.sv
// gvt_token_ring_node: one node of a token-ring Mattern GVT computation
// depends on gvtn_pkg, gvtn_if and gvtn_dest_div
//
// channels: cfg_ch writes node_id (0), node_count (1) and gvt_period (2);
// in_ch takes one event per item, out_ch returns exactly one result per item.
// an item goes into an input register, is evaluated against the node state by
// a single pass of compare/min/add logic and lands in the result register,
// where the state update commits. throughput is one item per cycle while the
// receiver takes results and no next-node index is being recomputed.
// when out_ch stalls the result holds and one more item is taken into the
// input register, then in_ch.ready drops until the result is taken.
// the next-node index needs (node_id+1) mod node_count: a remainder unit that
// takes one bit per cycle recomputes it after each write of node_id or
// node_count, and in_ch.ready stays low while it runs.
// cfg_ch.ready is always high. reset (rst_n low, synchronous) empties both
// registers and sets the state to white, zero balance, infinite minimums,
// no pending round, period counter and gvt at zero.
`default_nettype none

module gvt_token_ring_node import gvtn_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  gvtn_cfg_if.sink    cfg_ch,
  gvtn_in_if.sink     in_ch,
  gvtn_out_if.source  out_ch
);

  // configuration
  logic [ID_BITS-1:0]  node_id_r;
  logic [CNT_BITS-1:0] node_count_r;
  logic [PER_BITS-1:0] gvt_period_r;
  logic                cfg_wr;
  logic                div_start, div_busy;
  logic [ID_BITS-1:0]  dest;

  // node state
  logic                color_r, color_nxt;
  logic signed [31:0]  bal_r, bal_nxt;
  tstamp_t             rsm_r, rsm_nxt;
  logic                pend_r, pend_nxt;
  logic [PER_BITS-1:0] pc_r, pc_nxt;
  tstamp_t             lvt_r, lvt_nxt;
  tstamp_t             gvt_r, gvt_nxt;

  // pipeline
  logic     s1_valid_r, out_valid_r;
  in_item_t s1_r;
  res_t     out_r, res;
  logic     s1_adv, commit, in_acc;

  logic signed [31:0]  addend;
  logic signed [33:0]  sum;
  logic [PER_BITS-1:0] pc_inc;
  tstamp_t             rsm_base;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr    = cfg_ch.valid;
  assign div_start = cfg_wr && (cfg_ch.index == CFG_NODE_ID || cfg_ch.index == CFG_NODE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r    <= '0;
      node_count_r <= CNT_BITS'(1);
      gvt_period_r <= PER_BITS'(1);
    end else if (cfg_wr) begin
      case (cfg_ch.index)
        CFG_NODE_ID:    node_id_r    <= cfg_ch.data[ID_BITS-1:0];
        CFG_NODE_COUNT: node_count_r <= cfg_ch.data[CNT_BITS-1:0];
        CFG_GVT_PERIOD: gvt_period_r <= cfg_ch.data[PER_BITS-1:0];
        default: ;
      endcase
    end
  end

  gvtn_dest_div u_dest_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .node_id    ((cfg_ch.index == CFG_NODE_ID) ? cfg_ch.data[ID_BITS-1:0] : node_id_r),
    .node_count ((cfg_ch.index == CFG_NODE_COUNT) ? cfg_ch.data[CNT_BITS-1:0]
                                                   : node_count_r),
    .busy       (div_busy),
    .dest       (dest)
  );

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign commit      = s1_valid_r && s1_adv;
  assign in_ch.ready = !div_busy && (!s1_valid_r || s1_adv);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // one shared balance adder: +1, -1 or the token count
  always_comb begin
    case (s1_r.action)
      ACT_MSG_SENT: addend = 32'sd1;
      ACT_MSG_RECV: addend = -32'sd1;
      default:      addend = s1_r.in_count;
    endcase
    sum    = {{2{bal_r[31]}}, bal_r} + {{2{addend[31]}}, addend};
    pc_inc = pc_r + PER_BITS'(1);
    rsm_base = (color_r == COLOR_WHITE) ? TIME_INF : rsm_r;
  end

  always_comb begin
    color_nxt = color_r;
    bal_nxt   = bal_r;
    rsm_nxt   = rsm_r;
    pend_nxt  = pend_r;
    pc_nxt    = pc_r;
    lvt_nxt   = lvt_r;
    gvt_nxt   = gvt_r;
    res       = '0;
    case (s1_r.action)
      ACT_TICK: begin
        if (!pend_r) begin
          if (pc_inc == gvt_period_r) begin
            pc_nxt   = '0;
            res.flag = 1'b1;
          end else begin
            pc_nxt = pc_inc;
          end
        end
      end
      ACT_INITIATE: begin
        if (node_id_r == '0 && !pend_r) begin
          color_nxt = COLOR_RED;
          rsm_nxt   = TIME_INF;
          bal_nxt   = '0;
          pend_nxt  = 1'b1;
          res.flag  = 1'b1;
        end
      end
      ACT_MSG_SENT: begin
        if (color_r == COLOR_WHITE) begin
          bal_nxt = sat32(sum);
        end else begin
          rsm_nxt = tmin(rsm_r, s1_r.send_time);
        end
      end
      ACT_MSG_RECV: begin
        if (s1_r.recv_color == COLOR_WHITE) begin
          bal_nxt = sat32(sum);
        end
      end
      ACT_SEND_TOK: begin
        res.token_valid    = 1'b1;
        res.token_clock    = (node_id_r == '0) ? s1_r.lvt_local
                                               : tmin(s1_r.lvt_local, lvt_r);
        res.token_send_min = rsm_r;
        res.token_count    = bal_r;
        res.token_dest     = dest;
        bal_nxt            = '0;
      end
      ACT_TOK_ARR: begin
        if (node_id_r == '0) begin
          // round closes when the returning count cancels the local balance
          if (sum == '0) begin
            gvt_nxt       = tmin(s1_r.in_clock, s1_r.in_send_min);
            res.gvt_valid = 1'b1;
            pend_nxt      = 1'b0;
            bal_nxt       = '0;
            color_nxt     = COLOR_WHITE;
          end else begin
            rsm_nxt  = tmin(s1_r.in_send_min, rsm_r);
            res.flag = 1'b1;
          end
        end else begin
          color_nxt = COLOR_RED;
          lvt_nxt   = tmin(lvt_r, s1_r.in_clock);
          rsm_nxt   = tmin(s1_r.in_clock, rsm_base);
          bal_nxt   = sat32(sum);
          res.flag  = 1'b1;
        end
      end
      default: ;
    endcase
    res.tag_color = color_nxt;
    res.gvt_value = gvt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      color_r     <= COLOR_WHITE;
      bal_r       <= '0;
      rsm_r       <= TIME_INF;
      pend_r      <= 1'b0;
      pc_r        <= '0;
      lvt_r       <= TIME_INF;
      gvt_r       <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
        color_r     <= color_nxt;
        bal_r       <= bal_nxt;
        rsm_r       <= rsm_nxt;
        pend_r      <= pend_nxt;
        pc_r        <= pc_nxt;
        lvt_r       <= lvt_nxt;
        gvt_r       <= gvt_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.action      <= in_ch.action;
      s1_r.send_time   <= in_ch.send_time;
      s1_r.recv_color  <= in_ch.recv_color;
      s1_r.lvt_local   <= in_ch.lvt_local;
      s1_r.in_clock    <= in_ch.in_clock;
      s1_r.in_send_min <= in_ch.in_send_min;
      s1_r.in_count    <= in_ch.in_count;
    end
    if (commit) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.flag           = out_r.flag;
  assign out_ch.tag_color      = out_r.tag_color;
  assign out_ch.token_valid    = out_r.token_valid;
  assign out_ch.token_dest     = out_r.token_dest;
  assign out_ch.token_clock    = out_r.token_clock;
  assign out_ch.token_send_min = out_r.token_send_min;
  assign out_ch.token_count    = out_r.token_count;
  assign out_ch.gvt_valid      = out_r.gvt_valid;
  assign out_ch.gvt_value      = out_r.gvt_value;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !div_busy)
    else $error("item accepted while next-node index is being recomputed");
  a_pending_red: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> color_r == COLOR_RED)
    else $error("round pending while node is white");
  a_gvt_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.gvt_valid |-> !pend_r && out_r.gvt_value == gvt_r)
    else $error("gvt result without closing the round");
  a_idle_token_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.token_valid |->
      out_r.token_clock == '0 && out_r.token_send_min == '0 &&
      out_r.token_count == '0 && out_r.token_dest == '0)
    else $error("token fields set without a token");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps
// testbench: drives events into gvt_token_ring_node and checks every result item against
// an in-line model of one ring node; uses gvtn_pkg, gvtn_if and the node rtl

module testbench;
  import gvtn_pkg::*;

  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  logic clk;
  logic rst_n;

  gvtn_cfg_if cfg_ch ();
  gvtn_in_if  in_ch ();
  gvtn_out_if out_ch ();

  gvt_token_ring_node i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // node model: configuration and state
  logic [ID_BITS-1:0]  my_id;
  logic [CNT_BITS-1:0] ring_size;
  logic [PER_BITS-1:0] period;
  logic                color;
  logic signed [31:0]  balance;
  tstamp_t             red_min;
  logic                round_open;
  logic [PER_BITS-1:0] tick_count;
  tstamp_t             lvt_min;
  tstamp_t             gvt_now;

  in_item_t event_queue[$];
  res_t     due_results[$];

  in_item_t next_ev;
  in_item_t seen_ev;
  res_t     got;
  logic     in_fire = 1'b0;
  logic     res_fire = 1'b0;
  int       in_gap = 0;
  int       res_stall = 0;
  logic     steady = 1'b0;
  logic     hold_on = 1'b0;
  logic     pressure_req = 1'b0;

  int error_count = 0;
  int events_sent = 0;
  int results_seen = 0;
  int tokens_out = 0;
  int gvt_rounds = 0;
  int load_count = 0;
  int setting_count = 0;

  function automatic tstamp_t earlier(input tstamp_t a, input tstamp_t b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic signed [31:0] clamp_add(input logic signed [31:0] a,
                                                   input longint d);
    longint s;
    s = longint'(a) + d;
    if (s > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (s < -64'sd2147483648) return 32'sh8000_0000;
    return 32'(s);
  endfunction

  function automatic res_t apply_event(input in_item_t ev);
    res_t r;
    longint cnt;
    r = '0;
    cnt = longint'($signed(ev.in_count));
    case (ev.action)
      ACT_TICK: begin
        if (!round_open) begin
          tick_count = tick_count + PER_BITS'(1);
          if (tick_count == period) begin
            tick_count = '0;
            r.flag = 1'b1;
          end
        end
      end
      ACT_INITIATE: begin
        if (my_id == '0 && !round_open) begin
          color = COLOR_RED;
          red_min = TIME_INF;
          balance = '0;
          round_open = 1'b1;
          r.flag = 1'b1;
        end
      end
      ACT_MSG_SENT: begin
        if (color == COLOR_WHITE) balance = clamp_add(balance, 64'sd1);
        else red_min = earlier(red_min, ev.send_time);
      end
      ACT_MSG_RECV: begin
        if (ev.recv_color == COLOR_WHITE) balance = clamp_add(balance, -64'sd1);
      end
      ACT_SEND_TOK: begin
        r.token_valid = 1'b1;
        r.token_clock = (my_id == '0) ? ev.lvt_local : earlier(ev.lvt_local, lvt_min);
        r.token_send_min = red_min;
        r.token_count = balance;
        r.token_dest = (ring_size == '0) ? '0 :
                       ID_BITS'((int'(my_id) + 1) % int'(ring_size));
        balance = '0;
      end
      ACT_TOK_ARR: begin
        if (my_id == '0) begin
          // finish test uses the exact sum, no clamping
          if (longint'(balance) + cnt == 0) begin
            gvt_now = earlier(ev.in_clock, ev.in_send_min);
            r.gvt_valid = 1'b1;
            round_open = 1'b0;
            balance = '0;
            color = COLOR_WHITE;
          end else begin
            red_min = earlier(ev.in_send_min, red_min);
            r.flag = 1'b1;
          end
        end else begin
          if (color == COLOR_WHITE) begin
            red_min = TIME_INF;
            color = COLOR_RED;
          end
          lvt_min = earlier(lvt_min, ev.in_clock);
          red_min = earlier(ev.in_clock, red_min);
          balance = clamp_add(balance, cnt);
          r.flag = 1'b1;
        end
      end
      default: ;
    endcase
    r.tag_color = color;
    r.gvt_value = gvt_now;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    $display("error at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] val,
                             input logic [31:0] want);
    if (val !== want) begin
      flag_error($sformatf("result %0d: %s is %h, expected %h", results_seen, name, val, want));
    end
  endtask

  task automatic compare_result(input res_t val, input res_t want);
    check_field("flag", 32'(val.flag), 32'(want.flag));
    check_field("tag_color", 32'(val.tag_color), 32'(want.tag_color));
    check_field("token_valid", 32'(val.token_valid), 32'(want.token_valid));
    check_field("token_dest", 32'(val.token_dest), 32'(want.token_dest));
    check_field("token_clock", val.token_clock, want.token_clock);
    check_field("token_send_min", val.token_send_min, want.token_send_min);
    check_field("token_count", val.token_count, want.token_count);
    check_field("gvt_valid", 32'(val.gvt_valid), 32'(want.gvt_valid));
    check_field("gvt_value", val.gvt_value, want.gvt_value);
  endtask

  // monitor: results are checked before the item taken at the same edge is predicted
  always @(posedge clk) begin
    in_fire  <= rst_n && in_ch.valid && in_ch.ready;
    res_fire <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.flag           = out_ch.flag;
      got.tag_color      = out_ch.tag_color;
      got.token_valid    = out_ch.token_valid;
      got.token_dest     = out_ch.token_dest;
      got.token_clock    = out_ch.token_clock;
      got.token_send_min = out_ch.token_send_min;
      got.token_count    = out_ch.token_count;
      got.gvt_valid      = out_ch.gvt_valid;
      got.gvt_value      = out_ch.gvt_value;
      if (due_results.size() == 0) flag_error("result item with no item outstanding");
      else compare_result(got, due_results.pop_front());
      results_seen++;
      if (got.token_valid === 1'b1) tokens_out++;
      if (got.gvt_valid === 1'b1) gvt_rounds++;
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen_ev.action      = in_ch.action;
      seen_ev.send_time   = in_ch.send_time;
      seen_ev.recv_color  = in_ch.recv_color;
      seen_ev.lvt_local   = in_ch.lvt_local;
      seen_ev.in_clock    = in_ch.in_clock;
      seen_ev.in_send_min = in_ch.in_send_min;
      seen_ev.in_count    = in_ch.in_count;
      due_results.push_back(apply_event(seen_ev));
      events_sent++;
    end
  end

  // driver: one gap drawn per accepted item
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) in_gap = steady ? 0 : $urandom_range(0, 5);
      if (!in_ch.valid || in_fire) begin
        if (in_gap > 0) begin
          in_ch.valid <= 1'b0;
          in_gap--;
        end else if (event_queue.size() > 0) begin
          next_ev = event_queue.pop_front();
          in_ch.action      <= next_ev.action;
          in_ch.send_time   <= next_ev.send_time;
          in_ch.recv_color  <= next_ev.recv_color;
          in_ch.lvt_local   <= next_ev.lvt_local;
          in_ch.in_clock    <= next_ev.in_clock;
          in_ch.in_send_min <= next_ev.in_send_min;
          in_ch.in_count    <= next_ev.in_count;
          in_ch.valid       <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: one stall drawn per result item
  always @(negedge clk) begin
    if (res_fire) res_stall = steady ? 0 : $urandom_range(0, 5);
    if (!rst_n || hold_on) begin
      out_ch.ready <= 1'b0;
    end else if (res_stall > 0) begin
      out_ch.ready <= 1'b0;
      res_stall--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // long receiver hold-off so the node backs up into its input
  initial begin
    wait (pressure_req);
    hold_on = 1'b1;
    repeat (120) @(posedge clk);
    hold_on = 1'b0;
  end

  function automatic tstamp_t rand_stamp();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return TIME_INF;
      2, 3: return $urandom_range(0, 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_count();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      3, 4, 5: return 32'(int'($urandom_range(0, 10)) - 5);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t fresh_event(input logic [2:0] act);
    in_item_t ev;
    ev.action      = act;
    ev.send_time   = rand_stamp();
    ev.recv_color  = 1'($urandom_range(0, 1));
    ev.lvt_local   = rand_stamp();
    ev.in_clock    = rand_stamp();
    ev.in_send_min = rand_stamp();
    ev.in_count    = rand_count();
    return ev;
  endfunction

  task automatic queue_item(input in_item_t ev);
    event_queue.push_back(ev);
    if (ev.action <= ACT_TOK_ARR) load_count++;
  endtask

  task automatic queue_act(input logic [2:0] act);
    queue_item(fresh_event(act));
  endtask

  // initiator round: start, traffic, maybe a partial token, then one to cancel the balance
  task automatic queue_initiator_round();
    in_item_t ev;
    int tally;
    int steps;
    tally = 0;
    steps = $urandom_range(0, 8);
    queue_act(ACT_INITIATE);
    repeat (steps) begin
      ev = fresh_event(3'($urandom_range(ACT_TICK, ACT_SEND_TOK)));
      if (ev.action == ACT_MSG_RECV && ev.recv_color == COLOR_WHITE) tally--;
      if (ev.action == ACT_SEND_TOK) tally = 0;
      queue_item(ev);
    end
    if ($urandom_range(0, 2) == 0) begin
      ev = fresh_event(ACT_TOK_ARR);
      ev.in_count = 32'(-tally + int'($urandom_range(1, 3)));
      queue_item(ev);
    end
    ev = fresh_event(ACT_TOK_ARR);
    ev.in_count = 32'(-tally);
    queue_item(ev);
  endtask

  task automatic queue_relay_round();
    queue_act(ACT_TOK_ARR);
    repeat ($urandom_range(0, 6)) queue_act(3'($urandom_range(ACT_TICK, ACT_MSG_RECV)));
    queue_act(ACT_SEND_TOK);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_BITS'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_NODE_ID:    my_id = ID_BITS'(val);
      CFG_NODE_COUNT: ring_size = CNT_BITS'(val);
      CFG_GVT_PERIOD: period = PER_BITS'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_setting(input int unsigned id, input int unsigned cnt,
                               input int unsigned per);
    write_reg(CFG_NODE_ID, id);
    write_reg(CFG_NODE_COUNT, cnt);
    write_reg(CFG_GVT_PERIOD, per);
    setting_count++;
  endtask

  // all items taken and all results back, then a margin before the next phase
  task automatic wait_quiet();
    do @(posedge clk); while (event_queue.size() != 0 || in_ch.valid);
    do @(negedge clk); while (due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    in_item_t    ev;
    int unsigned id;
    int unsigned cnt;
    int unsigned per;
    int          budget;
    int          phase;

    rst_n = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.send_time = '0;
    in_ch.recv_color = COLOR_WHITE;
    in_ch.lvt_local = '0;
    in_ch.in_clock = '0;
    in_ch.in_send_min = '0;
    in_ch.in_count = '0;
    out_ch.ready = 1'b0;

    my_id = '0;
    ring_size = CNT_BITS'(1);
    period = PER_BITS'(1);
    color = COLOR_WHITE;
    balance = '0;
    red_min = TIME_INF;
    round_open = 1'b0;
    tick_count = '0;
    lvt_min = TIME_INF;
    gvt_now = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // initiator: period, ignored initiate, red minimum, partial and exact finish
    write_setting(0, 4, 3);
    repeat (3) queue_act(ACT_TICK);
    queue_act(ACT_INITIATE);
    queue_act(ACT_INITIATE);
    queue_act(ACT_TICK);
    ev = fresh_event(ACT_MSG_SENT);
    ev.send_time = TIME_INF;
    queue_item(ev);
    ev = fresh_event(ACT_MSG_SENT);
    ev.send_time = '0;
    queue_item(ev);
    ev = fresh_event(ACT_MSG_RECV);
    ev.recv_color = COLOR_WHITE;
    queue_item(ev);
    ev = fresh_event(ACT_MSG_RECV);
    ev.recv_color = COLOR_RED;
    queue_item(ev);
    ev = fresh_event(ACT_SEND_TOK);
    ev.lvt_local = TIME_INF;
    queue_item(ev);
    ev = fresh_event(ACT_TOK_ARR);
    ev.in_count = 32'sd5;
    queue_item(ev);
    ev = fresh_event(ACT_MSG_RECV);
    ev.recv_color = COLOR_WHITE;
    queue_item(ev);
    ev = fresh_event(ACT_TOK_ARR);
    ev.in_count = 32'sd1;
    ev.in_clock = TIME_INF;
    ev.in_send_min = 32'd7;
    queue_item(ev);
    queue_act(ACT_SPARE6);
    queue_act(ACT_SPARE7);
    queue_act(ACT_MSG_SENT);
    queue_act(ACT_MSG_SENT);
    // arrival with no round open still finishes
    ev = fresh_event(ACT_TOK_ARR);
    ev.in_count = -32'sd2;
    ev.in_clock = '0;
    ev.in_send_min = TIME_INF;
    queue_item(ev);
    ev = fresh_event(ACT_TOK_ARR);
    ev.in_count = 32'sh8000_0000;
    queue_item(ev);
    repeat (3) queue_act(ACT_TICK);
    wait_quiet();

    // last node of a full ring: balance clamps at both ends
    write_setting(1023, 1024, 65535);
    ev = fresh_event(ACT_TOK_ARR);
    ev.in_count = 32'sh7FFF_FFFF;
    ev.in_clock = 32'd100;
    queue_item(ev);
    ev.in_clock = TIME_INF;
    queue_item(ev);
    ev = fresh_event(ACT_MSG_SENT);
    ev.send_time = 32'd3;
    queue_item(ev);
    ev = fresh_event(ACT_SEND_TOK);
    ev.lvt_local = TIME_INF;
    queue_item(ev);
    ev = fresh_event(ACT_TOK_ARR);
    ev.in_count = 32'sh8000_0000;
    queue_item(ev);
    queue_item(ev);
    ev = fresh_event(ACT_MSG_RECV);
    ev.recv_color = COLOR_WHITE;
    queue_item(ev);
    ev = fresh_event(ACT_SEND_TOK);
    ev.lvt_local = '0;
    queue_item(ev);
    queue_act(ACT_INITIATE);
    queue_act(ACT_TICK);
    wait_quiet();

    // ring size zero and period zero: ticks count up without coming due
    write_setting(7, 0, 0);
    steady = 1'b1;
    queue_act(ACT_SEND_TOK);
    repeat (20) queue_act(ACT_TICK);
    queue_act(ACT_SEND_TOK);
    wait_quiet();
    steady = 1'b0;

    phase = 0;
    while (load_count < 1950) begin
      case ($urandom_range(0, 3))
        0, 1: id = 0;
        2: id = $urandom_range(1, 1023);
        default: id = 1023;
      endcase
      case ($urandom_range(0, 4))
        0: cnt = 1;
        1: cnt = 1024;
        2: cnt = id + 1;
        3: cnt = 0;
        default: cnt = $urandom_range(1, 1024);
      endcase
      case ($urandom_range(0, 4))
        0: per = 1;
        1: per = 65535;
        2: per = 0;
        default: per = $urandom_range(1, 6);
      endcase
      write_setting(id, cnt, per);
      steady = ($urandom_range(0, 3) == 0);
      budget = load_count + $urandom_range(100, 200);
      while (load_count < budget) begin
        if ($urandom_range(0, 3) == 0) queue_act(3'($urandom_range(ACT_TICK, ACT_SPARE7)));
        else if (my_id == '0) queue_initiator_round();
        else queue_relay_round();
      end
      if (phase == 1) pressure_req = 1'b1;
      wait_quiet();
      phase++;
    end

    $display("ran %0d items under %0d register settings, ring size and period zero included",
             events_sent, setting_count);
    $display("checked %0d results: %0d tokens sent, %0d gvt values computed",
             results_seen, tokens_out, gvt_rounds);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout: %0d items still queued, %0d results outstanding",
             event_queue.size(), due_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
